FILE: design/wse_pkg.sv
// wse_pkg: types, constants and the control program of the wheel speed estimator.
// No dependencies; every other design file uses it.
`timescale 1ns / 1ps
`default_nettype none

package wse_pkg;

	localparam int CIRC_W     = 12;
	localparam int PPR_W      = 8;
	localparam int SPEED_W    = 16;
	localparam int COUNT_W    = 32;
	localparam int TIME_W     = 48;
	localparam int INTERVAL_W = 32;
	localparam int NUM_W      = 32;
	localparam int DEN_W      = TIME_W + PPR_W;
	localparam int DIV_STEPS  = NUM_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W      = 19;
	localparam int RECIP_W    = 22;
	localparam int RECIP_SH   = 24;

	// 3600 s/h * 256 (8.8 fraction) folded with mm/us -> km/h
	localparam logic [19:0]         NUM_SCALE = 20'd921600;
	// ceil(2^24 / 5): exact floor(x/5) for x < 2^22
	localparam logic [RECIP_W-1:0]  RECIP5    = 22'd3355444;

	localparam logic [CIRC_W-1:0]  CIRC_RST = 12'd2105;
	localparam logic [PPR_W-1:0]   PPR_RST  = 8'd1;
	localparam logic [SPEED_W-1:0] THR_RST  = 16'd512;

	localparam logic [CFG_IDX_W-1:0] REG_CIRC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd2;

	typedef logic [2:0] step_t;

	typedef enum logic [2:0] {
		OP_CLASSIFY,
		OP_LOAD,
		OP_DIVIDE,
		OP_WAIT,
		OP_RAW,
		OP_BLEND,
		OP_SCALE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_SIMPLE,
		COND_DIV_BUSY,
		COND_BYPASS,
		COND_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		unique case (step)
			3'd0:    c = '{op: OP_CLASSIFY, cond: COND_SIMPLE,   target: 3'd7};
			3'd1:    c = '{op: OP_LOAD,     cond: COND_NEVER,    target: 3'd0};
			3'd2:    c = '{op: OP_DIVIDE,   cond: COND_NEVER,    target: 3'd0};
			3'd3:    c = '{op: OP_WAIT,     cond: COND_DIV_BUSY, target: 3'd3};
			3'd4:    c = '{op: OP_RAW,      cond: COND_NEVER,    target: 3'd0};
			3'd5:    c = '{op: OP_BLEND,    cond: COND_BYPASS,   target: 3'd7};
			3'd6:    c = '{op: OP_SCALE,    cond: COND_NEVER,    target: 3'd0};
			default: c = '{op: OP_EMIT,     cond: COND_OUT_FULL, target: 3'd7};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/wse_if.sv
// wse_if: valid/ready channel interfaces for samples, results and register writes.
// Depends on wse_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wse_sample_if;
	logic                              valid;
	logic                              ready;
	logic [wse_pkg::COUNT_W-1:0]       pulse_count;
	logic [wse_pkg::TIME_W-1:0]        pulse_time_us;
	logic [wse_pkg::INTERVAL_W-1:0]    interval_us;
	logic [wse_pkg::TIME_W-1:0]        now_us;
	modport source (output valid, pulse_count, pulse_time_us, interval_us, now_us,
		input ready);
	modport sink (input valid, pulse_count, pulse_time_us, interval_us, now_us,
		output ready);
endinterface

interface wse_result_if;
	logic                          valid;
	logic                          ready;
	logic [wse_pkg::SPEED_W-1:0]   raw_speed;
	logic [wse_pkg::SPEED_W-1:0]   filtered_speed;
	logic [wse_pkg::SPEED_W-1:0]   display_speed;
	modport source (output valid, raw_speed, filtered_speed, display_speed, input ready);
	modport sink (input valid, raw_speed, filtered_speed, display_speed, output ready);
endinterface

interface wse_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wse_pkg::CFG_IDX_W-1:0]   index;
	logic [wse_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/wheel_speed_estimator.sv
// wheel_speed_estimator: pulse-interval wheel speed estimator, top level.
// Depends on wse_pkg, wse_if (channel interfaces) and wse_div.
//
// Usage:
//  sample: one transaction per sensor snapshot (pulse count, pulse time,
//    interval, current time). result: one transaction per sample with raw,
//    filtered and display speed, unsigned 8.8 km/h.
//  cfg: register writes (0 circumference mm, 1 pulses per rev, 2 stop
//    threshold), always ready; write only while no sample is in flight.
//  A control program of eight steps runs per sample. Samples that need no
//    new speed (unknown interval, stopped, age within interval) jump from
//    classify straight to emit. Samples that compute a speed run the
//    bit-serial divider and skip the scale step when the blend is bypassed
//    (filter being seeded or speed below threshold).
//  sample.ready is high while no program runs, so a sample is accepted only
//    after the previous program ends; the result sits in an output register,
//    so the next sample is accepted while it waits. If the receiver stalls
//    and a second result is ready, the program holds at its last step.
//  Reset: state and speeds clear to zero, registers take 2105, 1, 512;
//    the block accepts a sample in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module wheel_speed_estimator (
	input  wire logic      clk,
	input  wire logic      arst_n,
	wse_sample_if.sink     sample,
	wse_result_if.source   result,
	wse_cfg_if.sink        cfg
);

	typedef enum logic {MODE_PULSE, MODE_DECAY} mode_t;

	// configuration
	logic [wse_pkg::CIRC_W-1:0]     circ_q;
	logic [wse_pkg::PPR_W-1:0]      ppr_q;
	logic [wse_pkg::SPEED_W-1:0]    thr_q;

	// estimator state
	logic [wse_pkg::COUNT_W-1:0]    seen_count_q;
	logic [wse_pkg::TIME_W-1:0]     seen_time_q;
	logic [wse_pkg::INTERVAL_W-1:0] kept_interval_q;
	logic [wse_pkg::SPEED_W-1:0]    raw_q;
	logic [wse_pkg::SPEED_W-1:0]    smooth_q;
	logic [wse_pkg::SPEED_W-1:0]    shown_q;
	logic                           interval_valid_q;

	// sequencer
	logic                           busy_q;
	wse_pkg::step_t                 step_q;
	mode_t                          mode_q;
	wse_pkg::ctrl_t                 ctrl;
	logic                           cond_hit;
	logic                           done;

	// datapath
	logic [wse_pkg::COUNT_W-1:0]    in_count_q;
	logic [wse_pkg::TIME_W-1:0]     in_ptime_q;
	logic [wse_pkg::INTERVAL_W-1:0] in_interval_q;
	logic [wse_pkg::TIME_W-1:0]     in_now_q;
	logic [wse_pkg::TIME_W-1:0]     t_q;
	logic [wse_pkg::DEN_W-1:0]      den_q;
	logic [wse_pkg::NUM_W-1:0]      num_q;
	logic [wse_pkg::SUM_W-1:0]      sum_q;

	logic                           out_valid_q;
	logic [wse_pkg::SPEED_W-1:0]    out_raw_q;
	logic [wse_pkg::SPEED_W-1:0]    out_filt_q;
	logic [wse_pkg::SPEED_W-1:0]    out_disp_q;

	logic                           accept;
	logic                           new_pulse;
	logic [wse_pkg::TIME_W-1:0]     age;
	logic                           age_over;
	logic                           simple;
	logic                           bypass;
	logic                           out_full;
	logic                           div_start;
	logic                           div_busy;
	logic [wse_pkg::NUM_W-1:0]      div_quot;
	logic [wse_pkg::SPEED_W-1:0]    sat_speed;
	logic [20:0]                    mix_pulse;
	logic [wse_pkg::SUM_W-1:0]      mix_decay;
	logic [wse_pkg::SUM_W+wse_pkg::RECIP_W-1:0] scaled;

	assign accept     = sample.valid && !busy_q;
	assign ctrl       = wse_pkg::ucode(step_q);

	assign new_pulse  = in_count_q != seen_count_q;
	assign age        = in_now_q - seen_time_q;
	assign age_over   = age > wse_pkg::TIME_W'(kept_interval_q);
	assign simple     = new_pulse ? (in_interval_q == '0)
		: (!interval_valid_q || seen_time_q == '0 || !age_over);
	assign bypass     = (mode_q == MODE_PULSE) ? (smooth_q == '0) : (raw_q < thr_q);
	assign out_full   = out_valid_q && !result.ready;

	always_comb begin
		case (ctrl.cond)
			wse_pkg::COND_SIMPLE:   cond_hit = simple;
			wse_pkg::COND_DIV_BUSY: cond_hit = div_busy;
			wse_pkg::COND_BYPASS:   cond_hit = bypass;
			wse_pkg::COND_OUT_FULL: cond_hit = out_full;
			default:                cond_hit = 1'b0;
		endcase
	end

	assign done      = busy_q && ctrl.op == wse_pkg::OP_EMIT && !out_full;
	assign div_start = busy_q && ctrl.op == wse_pkg::OP_DIVIDE;

	assign sat_speed = (div_quot[wse_pkg::NUM_W-1:wse_pkg::SPEED_W] != '0)
		? '1 : div_quot[wse_pkg::SPEED_W-1:0];
	assign mix_pulse = 21'(smooth_q) * 21'd13 + 21'(raw_q) * 21'd7;
	assign mix_decay = wse_pkg::SUM_W'({smooth_q, 2'b00}) + wse_pkg::SUM_W'(raw_q);
	assign scaled    = (wse_pkg::SUM_W+wse_pkg::RECIP_W)'(sum_q)
		* (wse_pkg::SUM_W+wse_pkg::RECIP_W)'(wse_pkg::RECIP5);

	wse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q           <= wse_pkg::CIRC_RST;
			ppr_q            <= wse_pkg::PPR_RST;
			thr_q            <= wse_pkg::THR_RST;
			seen_count_q     <= '0;
			seen_time_q      <= '0;
			kept_interval_q  <= '0;
			raw_q            <= '0;
			smooth_q         <= '0;
			shown_q          <= '0;
			interval_valid_q <= 1'b0;
			busy_q           <= 1'b0;
			step_q           <= '0;
			mode_q           <= MODE_PULSE;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					wse_pkg::REG_CIRC: circ_q <= cfg.data[wse_pkg::CIRC_W-1:0];
					wse_pkg::REG_PPR:  ppr_q  <= cfg.data[wse_pkg::PPR_W-1:0];
					wse_pkg::REG_THR:  thr_q  <= cfg.data;
					default: ;
				endcase
			end

			if (done)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (done) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= cond_hit ? ctrl.target : step_q + 1'b1;
				end

				unique case (ctrl.op)
					wse_pkg::OP_CLASSIFY: begin
						if (new_pulse) begin
							seen_count_q <= in_count_q;
							seen_time_q  <= in_ptime_q;
							mode_q       <= MODE_PULSE;
							if (in_interval_q != '0) begin
								kept_interval_q  <= in_interval_q;
								interval_valid_q <= 1'b1;
							end
						end else if (!interval_valid_q || seen_time_q == '0) begin
							raw_q    <= '0;
							smooth_q <= '0;
							shown_q  <= '0;
						end else begin
							mode_q <= MODE_DECAY;
							if (!age_over)
								shown_q <= smooth_q;
						end
					end
					wse_pkg::OP_RAW: raw_q <= sat_speed;
					wse_pkg::OP_BLEND: begin
						if (bypass) begin
							smooth_q <= (mode_q == MODE_PULSE) ? raw_q : '0;
							shown_q  <= (mode_q == MODE_PULSE) ? raw_q : '0;
						end
					end
					wse_pkg::OP_SCALE: begin
						smooth_q <= scaled[wse_pkg::RECIP_SH +: wse_pkg::SPEED_W];
						shown_q  <= scaled[wse_pkg::RECIP_SH +: wse_pkg::SPEED_W];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_count_q    <= sample.pulse_count;
			in_ptime_q    <= sample.pulse_time_us;
			in_interval_q <= sample.interval_us;
			in_now_q      <= sample.now_us;
		end
		if (busy_q) begin
			case (ctrl.op)
				wse_pkg::OP_CLASSIFY:
					t_q <= new_pulse ? wse_pkg::TIME_W'(in_interval_q) : age;
				wse_pkg::OP_LOAD: begin
					den_q <= wse_pkg::DEN_W'(t_q) * wse_pkg::DEN_W'(ppr_q);
					num_q <= wse_pkg::NUM_W'(circ_q) * wse_pkg::NUM_W'(wse_pkg::NUM_SCALE);
				end
				wse_pkg::OP_BLEND:
					sum_q <= (mode_q == MODE_PULSE) ? mix_pulse[20:2] : mix_decay;
				default: ;
			endcase
		end
		if (done) begin
			out_raw_q  <= raw_q;
			out_filt_q <= smooth_q;
			out_disp_q <= shown_q;
		end
	end

	assign sample.ready          = !busy_q;
	assign cfg.ready             = 1'b1;
	assign result.valid          = out_valid_q;
	assign result.raw_speed      = out_raw_q;
	assign result.filtered_speed = out_filt_q;
	assign result.display_speed  = out_disp_q;

endmodule

`default_nettype wire

FILE: design/wse_div.sv
// wse_div: restoring divider, one quotient bit per cycle.
// Depends on wse_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module wse_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wse_pkg::NUM_W-1:0]   num,
	input  wire logic [wse_pkg::DEN_W-1:0]   den,
	output logic                             busy,
	output logic [wse_pkg::NUM_W-1:0]        quot
);

	localparam int CNT_W = $clog2(wse_pkg::DIV_STEPS);
	localparam int NW    = wse_pkg::NUM_W;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     quot_q;
	logic [NW:0]       shifted;
	logic [NW:0]       diff;
	logic              ge;

	assign shifted = {rem_q, quot_q[NW-1]};
	assign ge      = wse_pkg::DEN_W'(shifted) >= den;
	assign diff    = shifted - den[NW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(wse_pkg::DIV_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[NW-1:0] : shifted[NW-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

FILE: design/wse_chk.sv
// wse_chk: port-level checks of wheel_speed_estimator, bound to the top level.
// Depends on wse_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module wse_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_valid,
	input wire logic                       s_ready,
	input wire logic                       r_valid,
	input wire logic                       r_ready,
	input wire logic [wse_pkg::SPEED_W-1:0] r_raw,
	input wire logic [wse_pkg::SPEED_W-1:0] r_filt,
	input wire logic [wse_pkg::SPEED_W-1:0] r_disp
);

	// one sample at a time: acceptance closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample accepted while a transaction is in flight");

	// input reopens only together with a fresh result
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_ready) |-> r_valid)
		else $error("input reopened without a result");

	// a result only appears while a sample is being processed
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result without a sample in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_raw) && $stable(r_filt)
			&& $stable(r_disp))
		else $error("stalled result transaction changed");

endmodule

bind wheel_speed_estimator wse_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_raw   (result.raw_speed),
	.r_filt  (result.filtered_speed),
	.r_disp  (result.display_speed)
);

`default_nettype wire

FILE: sim/tb_wheel_speed_estimator.sv
`timescale 1ns / 1ps
// tb_wheel_speed_estimator: self-checking bench for the wheel speed estimator.
// Needs wse_pkg, wse_if and the design. The scoreboard class predicts raw,
// filtered and display speed per sample and checks every result transaction.

typedef struct packed {
	logic [wse_pkg::COUNT_W-1:0]    count;
	logic [wse_pkg::TIME_W-1:0]     ptime;
	logic [wse_pkg::INTERVAL_W-1:0] interval;
	logic [wse_pkg::TIME_W-1:0]     now;
} sensor_sample_t;

typedef struct packed {
	logic [wse_pkg::SPEED_W-1:0] raw;
	logic [wse_pkg::SPEED_W-1:0] filtered;
	logic [wse_pkg::SPEED_W-1:0] display;
} speed_set_t;

class speed_scoreboard;
	logic [wse_pkg::CIRC_W-1:0]     circ_mm;
	logic [wse_pkg::PPR_W-1:0]      ppr;
	logic [wse_pkg::SPEED_W-1:0]    stop_thr;
	logic [wse_pkg::COUNT_W-1:0]    seen_count;
	logic [wse_pkg::TIME_W-1:0]     seen_ptime;
	logic [wse_pkg::INTERVAL_W-1:0] kept_iv;
	logic [wse_pkg::SPEED_W-1:0]    raw_v;
	logic [wse_pkg::SPEED_W-1:0]    smooth_v;
	logic [wse_pkg::SPEED_W-1:0]    shown_v;
	bit                             iv_known;
	speed_set_t                     expected_speeds[$];
	int                             mismatches;

	function new();
		circ_mm    = wse_pkg::CIRC_RST;
		ppr        = wse_pkg::PPR_RST;
		stop_thr   = wse_pkg::THR_RST;
		seen_count = '0;
		seen_ptime = '0;
		kept_iv    = '0;
		raw_v      = '0;
		smooth_v   = '0;
		shown_v    = '0;
		iv_known   = 1'b0;
		mismatches = 0;
	endfunction

	function void write_reg(input logic [wse_pkg::CFG_IDX_W-1:0] idx,
		input logic [wse_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			wse_pkg::REG_CIRC: circ_mm  = data[wse_pkg::CIRC_W-1:0];
			wse_pkg::REG_PPR:  ppr      = data[wse_pkg::PPR_W-1:0];
			wse_pkg::REG_THR:  stop_thr = data;
			default: ;
		endcase
	endfunction

	function logic [wse_pkg::SPEED_W-1:0] speed_for(input logic [wse_pkg::TIME_W-1:0] t_us);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		num = 64'(circ_mm) * 64'(wse_pkg::NUM_SCALE);
		den = 64'(t_us) * 64'(ppr);
		if (den == 64'd0)
			return '1;
		q = num / den;
		return (q > 64'hFFFF) ? '1 : q[15:0];
	endfunction

	function void note_sample(input sensor_sample_t s);
		logic [wse_pkg::TIME_W-1:0] age;
		logic [31:0]                mix;
		if (s.count != seen_count) begin
			seen_count = s.count;
			seen_ptime = s.ptime;
			if (s.interval != '0) begin
				kept_iv = s.interval;
				raw_v   = speed_for(48'(s.interval));
				if (smooth_v == '0) begin
					smooth_v = raw_v;
				end else begin
					mix      = (32'(smooth_v) * 13 + 32'(raw_v) * 7) / 20;
					smooth_v = mix[15:0];
				end
				shown_v  = smooth_v;
				iv_known = 1'b1;
			end
		end else if (!iv_known || seen_ptime == '0) begin
			raw_v    = '0;
			smooth_v = '0;
			shown_v  = '0;
		end else begin
			// age wraps modulo 2^48
			age = s.now - seen_ptime;
			if (age <= 48'(kept_iv)) begin
				shown_v = smooth_v;
			end else begin
				raw_v = speed_for(age);
				if (raw_v < stop_thr) begin
					smooth_v = '0;
					shown_v  = '0;
				end else begin
					mix      = (32'(smooth_v) * 4 + 32'(raw_v)) / 5;
					smooth_v = mix[15:0];
					shown_v  = smooth_v;
				end
			end
		end
		expected_speeds.push_back('{raw_v, smooth_v, shown_v});
	endfunction

	function void check_result(input speed_set_t got);
		speed_set_t want;
		if (expected_speeds.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: raw %0d filtered %0d display %0d",
					got.raw, got.filtered, got.display);
			return;
		end
		want = expected_speeds.pop_front();
		if (got.raw !== want.raw || got.filtered !== want.filtered
			|| got.display !== want.display) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: raw %0d/%0d filtered %0d/%0d display %0d/%0d (exp/act)",
					want.raw, got.raw, want.filtered, got.filtered,
					want.display, got.display);
		end
	endfunction

	function int pending();
		return expected_speeds.size();
	endfunction
endclass

module tb_wheel_speed_estimator;

	localparam logic [wse_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int MAX_GAP        = 10;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 115;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	wse_sample_if sample_bus ();
	wse_result_if result_bus ();
	wse_cfg_if    cfg_bus ();

	speed_scoreboard speeds;
	bit              no_idle;
	int              idle_cycles;

	logic [wse_pkg::COUNT_W-1:0]    ride_count;
	logic [wse_pkg::TIME_W-1:0]     ride_ptime;
	logic [wse_pkg::TIME_W-1:0]     ride_now;
	logic [wse_pkg::INTERVAL_W-1:0] ride_iv;

	wheel_speed_estimator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [wse_pkg::TIME_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[wse_pkg::TIME_W-1:0];
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic send_sample(input sensor_sample_t s);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid         <= 1'b1;
		sample_bus.pulse_count   <= s.count;
		sample_bus.pulse_time_us <= s.ptime;
		sample_bus.interval_us   <= s.interval;
		sample_bus.now_us        <= s.now;
		@(posedge clk);
		while (!sample_bus.ready) @(posedge clk);
		speeds.note_sample(s);
	endtask

	task automatic send_fields(input logic [wse_pkg::COUNT_W-1:0] count,
		input logic [wse_pkg::TIME_W-1:0] ptime,
		input logic [wse_pkg::INTERVAL_W-1:0] interval,
		input logic [wse_pkg::TIME_W-1:0] now);
		send_sample('{count, ptime, interval, now});
	endtask

	task automatic wait_idle(input int settle);
		sample_bus.valid <= 1'b0;
		while (speeds.pending() > 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wse_pkg::CFG_IDX_W-1:0] idx,
		input logic [wse_pkg::CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		speeds.write_reg(idx, data);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits are randomized
	task automatic set_config(input int circ, input int ppr, input int thr);
		wait_idle(SETTLE_CYCLES);
		write_reg(wse_pkg::REG_CIRC, {4'($urandom_range(0, 15)), 12'(circ)});
		write_reg(wse_pkg::REG_PPR, {8'($urandom_range(0, 255)), 8'(ppr)});
		write_reg(wse_pkg::REG_THR, 16'(thr));
	endtask

	// mostly a plausible ride: pulses with growing time, coasting, stops; rest is noise
	task automatic random_sample(output sensor_sample_t s);
		int pick;
		int shift;
		int mode;
		pick       = $urandom_range(0, 99);
		s.interval = $urandom();
		if (pick < 45) begin
			shift      = $urandom_range(3, 23);
			ride_iv    = $urandom_range(1 << shift, (2 << shift) - 1);
			ride_ptime = ride_now + $urandom_range(0, ride_iv);
			ride_now   = ride_ptime + $urandom_range(0, 500);
			ride_count = ride_count + (($urandom_range(0, 15) == 0) ? $urandom() : 1);
			s.interval = (pick < 38) ? ride_iv : '0;
		end else if (pick < 85) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0:       ride_now = ride_now + $urandom_range(0, ride_iv);
				1:       ride_now = ride_now + ride_iv + $urandom_range(0, ride_iv);
				2:       ride_now = ride_now + 48'(ride_iv) * $urandom_range(2, 40);
				default: ride_now = ride_now + $urandom_range(1000000, 30000000);
			endcase
		end else if (pick < 90) begin
			ride_count = ride_count + 1;
			ride_ptime = '0;
			ride_iv    = $urandom_range(1000, 200000);
			s.interval = ride_iv;
		end else begin
			if ($urandom_range(0, 1))
				ride_count = $urandom();
			ride_ptime = rand48();
			ride_now   = rand48();
			ride_iv    = $urandom_range(1000, 200000);
		end
		s.count = ride_count;
		s.ptime = ride_ptime;
		s.now   = ride_now;
	endtask

	always @(posedge clk) begin
		if (!arst_n || (sample_bus.valid && sample_bus.ready)
			|| (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		speed_set_t got;
		int         stall;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
			while (!result_bus.valid) @(posedge clk);
			got = '{result_bus.raw_speed, result_bus.filtered_speed, result_bus.display_speed};
			speeds.check_result(got);
		end
	end

	initial begin
		sensor_sample_t s;
		int             phase;
		int             n;
		speeds                   = new();
		no_idle                  = 1'b0;
		idle_cycles              = 0;
		sample_bus.valid         = 1'b0;
		sample_bus.pulse_count   = '0;
		sample_bus.pulse_time_us = '0;
		sample_bus.interval_us   = '0;
		sample_bus.now_us        = '0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.index            = wse_pkg::REG_CIRC;
		cfg_bus.data             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults
		send_fields(32'd0, 48'd0, 32'd0, 48'd0);
		send_fields(32'd1, 48'd5000, 32'd0, 48'd5000);
		send_fields(32'd1, 48'd5000, 32'hFFFF_FFFF, 48'd6000);
		send_fields(32'd2, 48'd105000, 32'd100000, 48'd105000);
		send_fields(32'd3, 48'd205000, 32'd90000, 48'd205100);
		send_fields(32'd3, 48'd205000, 32'd0, 48'd250000);
		send_fields(32'd3, 48'd205000, 32'd0, 48'd295000);
		send_fields(32'd3, 48'd205000, 32'd0, 48'd295001);
		send_fields(32'd3, 48'd205000, 32'd0, 48'd605000);
		send_fields(32'd3, 48'd205000, 32'd0, 48'd20205000);
		send_fields(32'd4, 48'hFFFF_FFFF_FFF0, 32'd1, 48'hFFFF_FFFF_FFF0);
		send_fields(32'd4, 48'hFFFF_FFFF_FFF0, 32'd0, 48'd5);
		send_fields(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_fields(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0, 48'd0);
		send_fields(32'd5, 48'd0, 32'd5000, 48'd100);
		send_fields(32'd5, 48'd0, 32'd0, 48'd200000);
		send_fields(32'd6, 48'd1000000, 32'd50000, 48'd1000000);
		send_fields(32'd6, 48'd1000000, 32'd0, 48'd0);

		// zero pulses per revolution, zero threshold
		wait_idle(SETTLE_CYCLES);
		write_reg(wse_pkg::REG_PPR, 16'hAB00);
		write_reg(wse_pkg::REG_THR, 16'd0);
		send_fields(32'd7, 48'd2000000, 32'd1000, 48'd2000000);
		send_fields(32'd7, 48'd2000000, 32'd0, 48'd2100000);

		// zero circumference
		wait_idle(SETTLE_CYCLES);
		write_reg(wse_pkg::REG_PPR, 16'h0001);
		write_reg(wse_pkg::REG_CIRC, 16'hF000);
		send_fields(32'd8, 48'd3000000, 32'd1000, 48'd3000000);
		send_fields(32'd8, 48'd3000000, 32'd0, 48'd4000000);

		// largest circumference, top threshold, write to the spare index
		wait_idle(SETTLE_CYCLES);
		write_reg(wse_pkg::REG_CIRC, 16'h0FFF);
		write_reg(wse_pkg::REG_THR, 16'hFFFF);
		write_reg(REG_SPARE, 16'h5A5A);
		send_fields(32'd9, 48'd5000000, 32'd30, 48'd5000000);
		send_fields(32'd9, 48'd5000000, 32'd0, 48'd5000100);

		ride_count = 32'd1000;
		ride_ptime = 48'd6000000;
		ride_now   = 48'd6000000;
		ride_iv    = 32'd100000;
		for (phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase % 4 == 3);
			case (phase)
				0: set_config(2105, 1, 512);
				1: set_config(4095, 1, 0);
				2: set_config(1, 255, 65535);
				3: set_config(4095, 255, 512);
				default: set_config($urandom_range(1, 4095), $urandom_range(1, 255),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 8192));
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_sample(s);
				send_sample(s);
			end
		end

		no_idle = 1'b0;
		wait_idle(DRAIN_CYCLES);
		if (speeds.mismatches == 0 && speeds.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
